[src/bole_pkg.sv]
// Shared types and constants for the bounded ordered list engine.
// Holds the command and status codes and the default list capacity.
// No dependencies.
package bole_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int SLOT_W       = 5;
  localparam int VALUE_W      = 32;

  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_AT    = 3'd5,
    KIND_DUMP      = 3'd6,
    KIND_NOP       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

endpackage

[src/bounded_ordered_list_engine.sv]
// Top level of the bounded ordered list engine.
// Depends on bole_pkg for command codes, status codes and the default capacity.
//
// Usage: commands arrive as beats on the input channel (kind, item_value, slot)
// and are taken when in_valid is high and in_stall is low. Results leave as
// beats on the output channel when out_valid is high and out_stall is low.
// The entries live in a small memory with one registered read port and one
// write port; a single index counter walks it under a sequencer, so the
// block takes one command at a time and holds in_stall high while it works.
// A status-only command goes to the response state, which loads its result
// into the output register; the block then returns to idle. An insert moves
// each entry by the step, shift-read and shift-write states, then writes the
// new item in the put state; a delete moves entries the same way and lowers
// the count in a final step. A dump reads and emits each entry beat in turn.
// One output register parts the channels: the next command is accepted while
// the last result still waits. When the receiver stalls, the result holds and
// the sequencer waits before loading the next beat. Reset clears the count and
// the output valid; entries are never read before they are written.
module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          kind,
  input  logic [VALUE_W-1:0]  item_value,
  input  logic [SLOT_W-1:0]   slot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [VALUE_W-1:0]  entry_value,
  output logic                is_entry,
  output logic                last,
  output logic [CNT_W-1:0]    length
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_STEP      = 8'b0000_0010,
    S_SHIFT_RD  = 8'b0000_0100,
    S_SHIFT_WR  = 8'b0000_1000,
    S_PUT       = 8'b0001_0000,
    S_DUMP_RD   = 8'b0010_0000,
    S_DUMP_EMIT = 8'b0100_0000,
    S_RESP      = 8'b1000_0000
  } state_t;

  state_t state;

  logic [VALUE_W-1:0] entries [CAPACITY];
  logic [VALUE_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   pos;
  logic               is_ins;
  logic [VALUE_W-1:0] value;
  status_t            res_status;

  logic               accept;
  logic               out_free;
  logic               beat_load;
  kind_t              cmd;
  logic               full;
  logic               empty;
  logic [CMP_W-1:0]   slot_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic               ins_slot_ok;
  logic               del_slot_ok;
  logic [CNT_W-1:0]   slot_pos;
  logic [CNT_W-1:0]   idx_up;
  logic [CNT_W-1:0]   idx_dn;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign beat_load = out_free && ((state == S_RESP) || (state == S_DUMP_EMIT));
  assign cmd       = kind_t'(kind);

  assign full        = (count == CNT_W'(CAPACITY));
  assign empty       = (count == '0);
  assign slot_ext    = CMP_W'(slot);
  assign cnt_ext     = CMP_W'(count);
  assign ins_slot_ok = (slot != '0) && (slot_ext <= cnt_ext + CMP_W'(1));
  assign del_slot_ok = (slot != '0) && (slot_ext <= cnt_ext);
  assign slot_pos    = CNT_W'(slot_ext - CMP_W'(1));
  assign idx_up      = idx + CNT_W'(1);
  assign idx_dn      = idx - CNT_W'(1);

  always_comb begin
    unique case (state)
      S_SHIFT_RD: rd_addr = is_ins ? idx_dn[IDX_W-1:0] : idx_up[IDX_W-1:0];
      S_DUMP_RD:  rd_addr = idx[IDX_W-1:0];
      default:    rd_addr = idx[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= entries[rd_addr];
    if (state == S_SHIFT_WR) begin
      entries[idx[IDX_W-1:0]] <= rd_data;
    end else if (state == S_PUT) begin
      entries[pos[IDX_W-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (beat_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else if (cmd == KIND_INS_AT && !ins_slot_ok) begin
                  res_status <= ST_BADPOS;
                  state      <= S_RESP;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_STEP;
                end
              end
              KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
                if (empty) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else if (cmd == KIND_DEL_AT && !del_slot_ok) begin
                  res_status <= ST_BADPOS;
                  state      <= S_RESP;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_STEP;
                end
              end
              KIND_DUMP: begin
                if (empty) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  state <= S_DUMP_RD;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_STEP: begin
          if (is_ins) begin
            state <= (idx > pos) ? S_SHIFT_RD : S_PUT;
          end else if (idx_up < count) begin
            state <= S_SHIFT_RD;
          end else begin
            count <= count - CNT_W'(1);
            state <= S_RESP;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          state <= S_STEP;
        end
        S_PUT: begin
          count <= count + CNT_W'(1);
          state <= S_RESP;
        end
        S_DUMP_RD: begin
          state <= S_DUMP_EMIT;
        end
        S_DUMP_EMIT: begin
          if (out_free) begin
            status      <= ST_OK;
            entry_value <= rd_data;
            is_entry    <= 1'b1;
            last        <= (idx_up == count);
            length      <= count;
            state       <= (idx_up == count) ? S_IDLE : S_DUMP_RD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            status      <= res_status;
            entry_value <= '0;
            is_entry    <= 1'b0;
            last        <= 1'b1;
            length      <= count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value <= item_value;
      unique case (cmd)
        KIND_INS_FRONT: begin
          is_ins <= 1'b1;
          pos    <= '0;
          idx    <= count;
        end
        KIND_INS_BACK: begin
          is_ins <= 1'b1;
          pos    <= count;
          idx    <= count;
        end
        KIND_INS_AT: begin
          is_ins <= 1'b1;
          pos    <= slot_pos;
          idx    <= count;
        end
        KIND_DEL_FRONT: begin
          is_ins <= 1'b0;
          pos    <= '0;
          idx    <= '0;
        end
        KIND_DEL_BACK: begin
          is_ins <= 1'b0;
          pos    <= count - CNT_W'(1);
          idx    <= count - CNT_W'(1);
        end
        KIND_DEL_AT: begin
          is_ins <= 1'b0;
          pos    <= slot_pos;
          idx    <= slot_pos;
        end
        default: begin
          is_ins <= 1'b0;
          pos    <= '0;
          idx    <= '0;
        end
      endcase
    end else if (state == S_SHIFT_WR) begin
      idx <= is_ins ? idx_dn : idx_up;
    end else if (state == S_DUMP_EMIT && out_free) begin
      idx <= idx_up;
    end
  end

endmodule

[sim/tb.sv]
// Self-checking bench for bounded_ordered_list_engine: a directed command table, then random
// fill, drain and mixed bursts. Depends on bole_pkg and the engine RTL. A list model kept
// here predicts the result beats; typed table rows give their own status and length.
module tb;
  import bole_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    status_t     st;
    logic [31:0] value;
    logic        is_entry;
    logic        last;
    logic [4:0]  len;
  } result_beat_t;

  typedef struct {
    kind_t       op;
    logic [31:0] value;
    logic [4:0]  slot;
    bit          typed;
    status_t     want_status;
    logic [4:0]  want_len;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  kind_t       cmd_kind = KIND_NOP;
  logic [31:0] item_value = '0;
  logic [4:0]  slot = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] entry_value;
  logic        is_entry;
  logic        last;
  logic [4:0]  length;

  logic [31:0]  shadow_list [CAPACITY_DEF];
  int           shadow_len = 0;
  result_beat_t pending_results [$];
  result_beat_t want_beat;
  int           fail_count = 0;
  int           send_idle_pct = 15;
  int           recv_idle_pct = 85;
  int           beats_seen = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  dir_row_t dir_rows [22] = '{
    '{KIND_DEL_FRONT, 32'h0000_0000, 5'd0,  1'b1, ST_EMPTY,  5'd0},
    '{KIND_DEL_BACK,  32'h0000_0000, 5'd0,  1'b1, ST_EMPTY,  5'd0},
    '{KIND_DEL_AT,    32'h0000_0000, 5'd0,  1'b1, ST_EMPTY,  5'd0},
    '{KIND_DEL_AT,    32'h0000_0000, 5'd31, 1'b1, ST_EMPTY,  5'd0},
    '{KIND_DUMP,      32'h0000_0000, 5'd0,  1'b1, ST_EMPTY,  5'd0},
    '{KIND_INS_AT,    32'h0000_0005, 5'd0,  1'b1, ST_BADPOS, 5'd0},
    '{KIND_INS_AT,    32'h0000_0005, 5'd2,  1'b1, ST_BADPOS, 5'd0},
    '{KIND_INS_FRONT, 32'h7FFF_FFFF, 5'd0,  1'b1, ST_OK,     5'd1},
    '{KIND_INS_BACK,  32'h8000_0000, 5'd31, 1'b1, ST_OK,     5'd2},
    '{KIND_INS_AT,    32'hFFFF_FFFF, 5'd3,  1'b1, ST_OK,     5'd3},
    '{KIND_INS_AT,    32'h0000_0000, 5'd1,  1'b1, ST_OK,     5'd4},
    '{KIND_DUMP,      32'h0000_0000, 5'd0,  1'b0, ST_OK,     5'd0},
    '{KIND_DEL_AT,    32'h0000_0000, 5'd5,  1'b1, ST_BADPOS, 5'd4},
    '{KIND_DEL_AT,    32'h0000_0000, 5'd0,  1'b1, ST_BADPOS, 5'd4},
    '{KIND_DEL_AT,    32'h0000_0000, 5'd31, 1'b1, ST_BADPOS, 5'd4},
    '{KIND_NOP,       32'hFFFF_FFFF, 5'd31, 1'b1, ST_OK,     5'd4},
    '{KIND_INS_AT,    32'h5555_5555, 5'd5,  1'b1, ST_OK,     5'd5},
    '{KIND_DEL_AT,    32'h0000_0000, 5'd2,  1'b1, ST_OK,     5'd4},
    '{KIND_DEL_FRONT, 32'h0000_0000, 5'd0,  1'b1, ST_OK,     5'd3},
    '{KIND_DEL_BACK,  32'h0000_0000, 5'd0,  1'b1, ST_OK,     5'd2},
    '{KIND_DUMP,      32'h0000_0000, 5'd0,  1'b0, ST_OK,     5'd0},
    '{KIND_INS_AT,    32'hAAAA_AAAA, 5'd16, 1'b1, ST_BADPOS, 5'd2}
  };

  bounded_ordered_list_engine u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (cmd_kind),
    .item_value  (item_value),
    .slot        (slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_value (entry_value),
    .is_entry    (is_entry),
    .last        (last),
    .length      (length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void list_apply(kind_t op, logic [31:0] value, logic [4:0] pos_1);
    status_t st;
    int      pos;
    int      i;
    st = ST_OK;
    case (op)
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
        pos = (op == KIND_INS_FRONT) ? 0 : (op == KIND_INS_BACK) ? shadow_len : int'(pos_1) - 1;
        if (shadow_len >= CAPACITY_DEF) begin
          st = ST_FULL;
        end else if (pos < 0 || pos > shadow_len) begin
          st = ST_BADPOS;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = value;
          shadow_len++;
        end
      end
      KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
        pos = (op == KIND_DEL_FRONT) ? 0 : (op == KIND_DEL_BACK) ? shadow_len - 1 :
              int'(pos_1) - 1;
        if (shadow_len == 0) begin
          st = ST_EMPTY;
        end else if (pos < 0 || pos >= shadow_len) begin
          st = ST_BADPOS;
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      KIND_DUMP: begin
        if (shadow_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            pending_results.push_back('{ST_OK, shadow_list[i], 1'b1, (i + 1 == shadow_len),
                                        5'(shadow_len)});
          end
          return;
        end
      end
      default: st = ST_OK;
    endcase
    pending_results.push_back('{st, 32'd0, 1'b0, 1'b1, 5'(shadow_len)});
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_cmd(kind_t op, logic [31:0] value, logic [4:0] pos_1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd_kind   <= op;
    item_value <= value;
    slot       <= pos_1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    list_apply(op, value, pos_1);
  endtask

  task automatic run_bursts(int n_items);
    int          sent;
    int          mode;
    int          n;
    int          j;
    kind_t       op;
    logic [31:0] value;
    logic [4:0]  pos_1;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(9);
      n = (mode < 6) ? 16 + $urandom_range(4) : 6 + $urandom_range(6);
      for (j = 0; j < n && sent < n_items; j++) begin
        if (mode < 3) op = kind_t'($urandom_range(2));
        else if (mode < 6) op = kind_t'(3 + $urandom_range(2));
        else op = kind_t'($urandom_range(7));
        case ($urandom_range(7))
          0: value = 32'h7FFF_FFFF;
          1: value = 32'h8000_0000;
          default: value = $urandom();
        endcase
        if ($urandom_range(4) == 0) pos_1 = 5'($urandom_range(31));
        else pos_1 = 5'($urandom_range(shadow_len + 2));
        send_cmd(op, value, pos_1);
        sent++;
      end
      send_cmd(KIND_DUMP, $urandom(), 5'($urandom_range(31)));
      sent++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d value %0h",
                 $time, status, entry_value);
        fail_count++;
      end else begin
        want_beat = pending_results.pop_front();
        field_check("status", 32'(want_beat.st), 32'(status));
        field_check("entry_value", want_beat.value, entry_value);
        field_check("is_entry", 32'(want_beat.is_entry), 32'(is_entry));
        field_check("last", 32'(want_beat.last), 32'(last));
        field_check("length", 32'(want_beat.len), 32'(length));
        beats_seen++;
        if (beats_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].op, dir_rows[i].value, dir_rows[i].slot);
      if (dir_rows[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back('{dir_rows[i].want_status, 32'd0, 1'b0, 1'b1,
                                    dir_rows[i].want_len});
      end
    end
    run_bursts(79);
    send_idle_pct = 85;
    recv_idle_pct = 15;
    run_bursts(79);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_bursts(79);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/bole_pkg.sv
src/bounded_ordered_list_engine.sv
sim/tb.sv
